>>> hw/rtl/trbf_pkg.sv
`timescale 1ns / 1ps

package trbf_pkg;

  // Request command codes
  typedef enum logic [1:0] {
    CMD_GET    = 2'd0,
    CMD_EVENT  = 2'd1,
    CMD_EEPROM = 2'd2,
    CMD_I2C    = 2'd3
  } cmd_e;

  // Configuration register indexes
  localparam logic [1:0] REG_EVENT_TAG  = 2'd0;
  localparam logic [1:0] REG_EEPROM_TAG = 2'd1;
  localparam logic [1:0] REG_I2C_TAG    = 2'd2;

  // Reset values of the tag registers
  localparam logic [7:0] EVENT_TAG_RST  = 8'd1;
  localparam logic [7:0] EEPROM_TAG_RST = 8'd2;
  localparam logic [7:0] I2C_TAG_RST    = 8'd3;

  // Record lengths in bytes, tag included
  localparam logic [2:0] LEN_EVENT  = 3'd4;
  localparam logic [2:0] LEN_EEPROM = 3'd3;
  localparam logic [2:0] LEN_I2C    = 3'd5;

  // Byte answered when nothing is popped
  localparam logic [7:0] EMPTY_READ = 8'hFF;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_WRITE = 2'd1,
    ST_READ  = 2'd2,
    ST_DONE  = 2'd3
  } state_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic accept;  // latch the request and its admission result
    logic wr;      // write the current record byte
    logic rd;      // pop one byte into the read register
    logic done;    // load the result register
  } ctl_t;

  // Status from datapath to controller
  typedef struct packed {
    logic in_get;    // pending request is a get
    logic in_ok;     // pending request will change the FIFO
    logic last_byte; // current record byte is the last one
    logic out_free;  // result register can take a new result
  } sts_t;

endpackage

>>> hw/rtl/trbf_if.sv
`timescale 1ns / 1ps

// Request channel: one command with its payload bytes
interface trbf_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [7:0] byte_a;
  logic [7:0] byte_b;
  logic [7:0] byte_c;
  logic [7:0] byte_d;

  modport source (output valid, command, byte_a, byte_b, byte_c, byte_d, input ready);
  modport sink (input valid, command, byte_a, byte_b, byte_c, byte_d, output ready);
endinterface

// Result channel: one result per request
interface trbf_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_byte;
  logic       popped;
  logic       accepted;
  logic [6:0] free_count;
  logic       is_empty;
  logic       is_full;

  modport source (output valid, read_byte, popped, accepted, free_count, is_empty, is_full,
                  input ready);
  modport sink (input valid, read_byte, popped, accepted, free_count, is_empty, is_full,
                output ready);
endinterface

>>> hw/rtl/trbf_ctrl.sv
`timescale 1ns / 1ps

module trbf_ctrl
  import trbf_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output ctl_t ctl_o
);

  state_e state_q, state_d;

  // Advance the state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (!sts_i.in_ok) begin
            state_d = ST_DONE;
          end else if (sts_i.in_get) begin
            state_d = ST_READ;
          end else begin
            state_d = ST_WRITE;
          end
        end
      end
      ST_WRITE: begin
        if (sts_i.last_byte) begin
          state_d = ST_DONE;
        end
      end
      ST_READ: begin
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (sts_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_ready_o = 1'b0;
    ctl_o      = '0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o   = 1'b1;
        ctl_o.accept = in_valid_i;
      end
      ST_WRITE: ctl_o.wr = 1'b1;
      ST_READ:  ctl_o.rd = 1'b1;
      ST_DONE:  ctl_o.done = sts_i.out_free;
      default: ;
    endcase
  end

endmodule

>>> hw/rtl/trbf_dp.sv
`timescale 1ns / 1ps

module trbf_dp
  import trbf_pkg::*;
#(
  parameter int unsigned DEPTH = 64
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [1:0]    cfg_idx_i,
  input  logic [7:0]    cfg_data_i,
  trbf_req_if.sink      req_i,
  trbf_rsp_if.source    rsp_o,
  input  ctl_t          ctl_i,
  output sts_t          sts_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);

  logic [7:0]    event_tag_q, eeprom_tag_q, i2c_tag_q;
  logic [7:0]    mem_q [DEPTH];
  logic [PW-1:0] rp_q, wp_q, rp_nxt, wp_nxt;
  logic [CW-1:0] free_q;
  logic          empty_q, full_q;
  cmd_e          cmd_q, cmd_in;
  logic          ok_q;
  logic [7:0]    a_q, b_q, c_q, d_q;
  logic [2:0]    idx_q;
  logic [7:0]    rdata_q;
  logic [7:0]    wbyte;
  logic [7:0]    tag_sel;
  logic          rsp_valid_q;

  assign cmd_in = cmd_e'(req_i.command);
  assign rp_nxt = (rp_q == LAST_SLOT) ? '0 : rp_q + 1'b1;
  assign wp_nxt = (wp_q == LAST_SLOT) ? '0 : wp_q + 1'b1;

  // Status toward the controller
  always_comb begin
    // Admission check on the pending request
    sts_o.in_get = (cmd_in == CMD_GET);
    case (cmd_in)
      CMD_GET:    sts_o.in_ok = !empty_q;
      CMD_EVENT:  sts_o.in_ok = (free_q >= CW'(LEN_EVENT));
      CMD_EEPROM: sts_o.in_ok = (free_q >= CW'(LEN_EEPROM));
      default:    sts_o.in_ok = (free_q >= CW'(LEN_I2C));
    endcase
    // Flag the last byte of the record being written
    case (cmd_q)
      CMD_EVENT:  sts_o.last_byte = (idx_q == LEN_EVENT - 3'd1);
      CMD_EEPROM: sts_o.last_byte = (idx_q == LEN_EEPROM - 3'd1);
      default:    sts_o.last_byte = (idx_q == LEN_I2C - 3'd1);
    endcase
    sts_o.out_free = !rsp_valid_q || rsp_o.ready;
  end

  // Pick the record byte for the current slot
  always_comb begin
    case (cmd_q)
      CMD_EVENT:  tag_sel = event_tag_q;
      CMD_EEPROM: tag_sel = eeprom_tag_q;
      default:    tag_sel = i2c_tag_q;
    endcase
    case (idx_q)
      3'd0:    wbyte = tag_sel;
      3'd1:    wbyte = a_q;
      3'd2:    wbyte = b_q;
      3'd3:    wbyte = c_q;
      default: wbyte = d_q;
    endcase
  end

  // Tag registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      event_tag_q  <= EVENT_TAG_RST;
      eeprom_tag_q <= EEPROM_TAG_RST;
      i2c_tag_q    <= I2C_TAG_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_EVENT_TAG:  event_tag_q  <= cfg_data_i;
        REG_EEPROM_TAG: eeprom_tag_q <= cfg_data_i;
        REG_I2C_TAG:    i2c_tag_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Hold the request payload
  always_ff @(posedge clk_i) begin
    if (ctl_i.accept) begin
      a_q <= req_i.byte_a;
      b_q <= req_i.byte_b;
      c_q <= req_i.byte_c;
      d_q <= req_i.byte_d;
    end
  end

  // Request command, admission result and record byte index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_q <= CMD_GET;
      ok_q  <= 1'b0;
      idx_q <= '0;
    end else if (ctl_i.accept) begin
      cmd_q <= cmd_in;
      ok_q  <= sts_o.in_ok;
      idx_q <= '0;
    end else if (ctl_i.wr) begin
      idx_q <= idx_q + 3'd1;
    end
  end

  // Ring storage: one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (ctl_i.wr) begin
      mem_q[wp_q] <= wbyte;
    end
    if (ctl_i.rd) begin
      rdata_q <= mem_q[rp_q];
    end
  end

  // Pointers, free count and flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rp_q    <= '0;
      wp_q    <= '0;
      free_q  <= CW'(DEPTH);
      empty_q <= 1'b1;
      full_q  <= 1'b0;
    end else if (ctl_i.wr) begin
      wp_q    <= wp_nxt;
      free_q  <= free_q - 1'b1;
      empty_q <= 1'b0;
      full_q  <= (wp_nxt == rp_q);
    end else if (ctl_i.rd) begin
      rp_q    <= rp_nxt;
      free_q  <= free_q + 1'b1;
      full_q  <= 1'b0;
      empty_q <= (rp_nxt == wp_q);
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (ctl_i.done) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.done) begin
      rsp_o.read_byte  <= (cmd_q == CMD_GET && ok_q) ? rdata_q : EMPTY_READ;
      rsp_o.popped     <= (cmd_q == CMD_GET) && ok_q;
      rsp_o.accepted   <= (cmd_q != CMD_GET) && ok_q;
      rsp_o.free_count <= 7'(free_q);
      rsp_o.is_empty   <= empty_q;
      rsp_o.is_full    <= full_q;
    end
  end

  assign rsp_o.valid = rsp_valid_q;

endmodule

>>> hw/rtl/tagged_record_byte_fifo_unit.sv
`timescale 1ns / 1ps

// Byte-wide circular FIFO of DEPTH slots holding tagged records. Each request
// is a get (pop one byte, 0xFF when empty) or a put of an event (4 bytes),
// EEPROM write (3 bytes) or I2C command (5 bytes) record; a put that does not
// fit is dropped whole. The type tag written ahead of each record comes from
// configuration registers 0 to 2. Every request yields one result carrying
// the popped byte, popped/accepted flags, free count and empty/full flags.
// One request is handled at a time: a get passes accept, memory read and
// result; a put writes its record bytes one per cycle through the single
// memory write port between accept and result; a dropped put goes straight
// to result. A new request is taken while the previous result waits.

module tagged_record_byte_fifo_unit
  import trbf_pkg::*;
#(
  parameter int unsigned DEPTH = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_idx_i,
  input  logic [7:0] cfg_data_i,
  trbf_req_if.sink   req_i,
  trbf_rsp_if.source rsp_o
);

  ctl_t ctl;
  sts_t sts;

  trbf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (req_i.ready),
    .sts_i      (sts),
    .ctl_o      (ctl)
  );

  trbf_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .req_i      (req_i),
    .rsp_o      (rsp_o),
    .ctl_i      (ctl),
    .sts_o      (sts)
  );

endmodule
